// ----- sv/riscv_call_return_tracer_defines.svh -----
// Assertion macros shared by the call and return tracer modules.
`ifndef RISCV_CALL_RETURN_TRACER_DEFINES_SVH
`define RISCV_CALL_RETURN_TRACER_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define RCRT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define RCRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/rcrt_pkg.sv -----
// Package with the constants, codes and types of the call and return tracer.
`default_nettype none

package rcrt_pkg;

   localparam int SYMBOL_ENTRIES = 256;
   localparam int STACK_ENTRIES  = 512;

   localparam int SYM_AW  = $clog2(SYMBOL_ENTRIES);
   localparam int SCNT_W  = $clog2(SYMBOL_ENTRIES + 1);
   localparam int STK_AW  = $clog2(STACK_ENTRIES);
   localparam int LVL_W   = $clog2(STACK_ENTRIES + 1);

   localparam logic       CMD_LOAD  = 1'b0;
   localparam logic       CMD_TRACE = 1'b1;

   localparam logic [1:0] EVT_NONE = 2'd0;
   localparam logic [1:0] EVT_CALL = 2'd1;
   localparam logic [1:0] EVT_RET  = 2'd2;

   localparam logic [11:0] LOW_JALR = 12'h0E7;
   localparam logic [11:0] LOW_JAL  = 12'h0EF;
   localparam logic [31:0] INST_RET = 32'h0000_8067;
   localparam logic [31:0] ALIGN_MASK = 32'hFFFF_FFFE;
   localparam logic [31:0] RET_STEP   = 32'h0000_0004;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PC_RD,
      S_PC_CMP,
      S_DECODE,
      S_POP_RD,
      S_POP_WAIT,
      S_TGT_RD,
      S_TGT_CMP,
      S_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic trace_start;
      logic scan_next;
      logic call;
      logic ret;
      logic pop_take;
      logic callee_hit;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_end;
      logic hit;
      logic is_call;
      logic is_ret;
      logic stack_empty;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

// ----- sv/rcrt_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module rcrt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- sv/rcrt_ctrl.sv -----
// Controller state machine that sequences table scans, stack moves and result hand-off.
`default_nettype none

module rcrt_ctrl
   import rcrt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          req_command,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

`include "riscv_call_return_tracer_defines.svh"

   state_type state_ff;
   state_type state_in;
   logic      req_fire;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = (req_command == CMD_TRACE) ? S_PC_RD : S_DONE;
            end
         end
         S_PC_RD: begin
            state_in = status.scan_end ? S_DONE : S_PC_CMP;
         end
         S_PC_CMP: begin
            state_in = status.hit ? S_DECODE : S_PC_RD;
         end
         S_DECODE: begin
            if (status.is_call) begin
               state_in = S_TGT_RD;
            end else if (status.is_ret && !status.stack_empty) begin
               state_in = S_POP_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_POP_RD: begin
            state_in = S_POP_WAIT;
         end
         S_POP_WAIT: begin
            state_in = S_TGT_RD;
         end
         S_TGT_RD: begin
            state_in = status.scan_end ? S_DONE : S_TGT_CMP;
         end
         S_TGT_CMP: begin
            state_in = status.hit ? S_DONE : S_TGT_RD;
         end
         S_DONE: begin
            if (status.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.load        = req_fire && (req_command == CMD_LOAD);
            cmd.trace_start = req_fire && (req_command == CMD_TRACE);
         end
         S_PC_CMP: begin
            cmd.scan_next = !status.hit;
         end
         S_DECODE: begin
            cmd.call = status.is_call;
            cmd.ret  = !status.is_call && status.is_ret;
         end
         S_POP_WAIT: begin
            cmd.pop_take = 1'b1;
         end
         S_TGT_CMP: begin
            cmd.callee_hit = status.hit;
            cmd.scan_next  = !status.hit;
         end
         S_DONE: begin
            cmd.emit = status.out_free;
         end
         S_PC_RD, S_POP_RD, S_TGT_RD: begin
            cmd = '0;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   `RCRT_ASSERT_NEXT(a_trace_starts_scan, clock, reset, req_fire && (req_command == CMD_TRACE), state_ff == S_PC_RD, "trace item did not start the pc scan")
   `RCRT_ASSERT_NEXT(a_load_goes_done, clock, reset, req_fire && (req_command == CMD_LOAD), state_ff == S_DONE, "load item did not go to result hand-off")
   `RCRT_ASSERT_NOW(a_emit_only_done, clock, reset, cmd.emit, state_ff == S_DONE && status.out_free, "result emitted outside hand-off")

endmodule

`default_nettype wire

// ----- sv/rcrt_dp.sv -----
// Datapath with the symbol range table, return stack, lookup scanner and result registers.
`default_nettype none

module rcrt_dp
   import rcrt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  ctrl_cmd_type  cmd,
   output dp_status_type status,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [8:0]    csr_symbol_count,
   input  logic [7:0]    req_entry_index,
   input  logic [31:0]   req_entry_base,
   input  logic [31:0]   req_entry_size,
   input  logic [31:0]   req_instruction,
   input  logic [31:0]   req_program_counter,
   input  logic [31:0]   req_rs1_value,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [1:0]    rsp_event_kind,
   output logic [7:0]    rsp_caller_index,
   output logic [7:0]    rsp_callee_index,
   output logic          rsp_callee_found,
   output logic [31:0]   rsp_target_address,
   output logic [9:0]    rsp_call_depth,
   output logic          rsp_stack_error
);

`include "riscv_call_return_tracer_defines.svh"

   logic [8:0]        symbol_count_ff;
   logic [LVL_W-1:0]  level_ff, level_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SCNT_W-1:0] scan_idx_ff, scan_idx_in;
   logic [31:0]       inst_ff, pc_ff, rs1_ff, key_ff;
   logic [31:0]       inst_in, pc_in, rs1_in, key_in;

   logic [1:0]        kind_ff, kind_in;
   logic [7:0]        caller_ff, caller_in, callee_ff, callee_in;
   logic              found_ff, found_in, err_ff, err_in;
   logic [31:0]       target_ff, target_in;
   logic [9:0]        depth_ff, depth_in;

   logic [1:0]        rsp_kind_ff;
   logic [7:0]        rsp_caller_ff, rsp_callee_ff;
   logic              rsp_found_ff, rsp_err_ff;
   logic [31:0]       rsp_target_ff;
   logic [9:0]        rsp_depth_ff;

   logic [SCNT_W-1:0] active_n;
   logic [63:0]       tbl_rd_data;
   logic [31:0]       tbl_base, tbl_size, key_off;
   logic [31:0]       stk_rd_data;
   logic              tbl_wr_en, stk_wr_en, stack_full, stack_empty;
   logic [11:0]       inst_low;
   logic [31:0]       jal_imm, jalr_imm, call_target;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         symbol_count_ff <= '0;
      end else if (csr_valid) begin
         symbol_count_ff <= csr_symbol_count;
      end
   end

   // Symbol table: base in the low word, size in the high word.
   assign tbl_wr_en = cmd.load && (32'(req_entry_index) < 32'(SYMBOL_ENTRIES));

   rcrt_ram #(
      .WIDTH (64),
      .DEPTH (SYMBOL_ENTRIES)
   ) u_tbl_ram (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (SYM_AW'(req_entry_index)),
      .wr_data ({req_entry_size, req_entry_base}),
      .rd_addr (scan_idx_ff[SYM_AW-1:0]),
      .rd_data (tbl_rd_data)
   );

   assign stack_full  = (level_ff >= LVL_W'(STACK_ENTRIES));
   assign stack_empty = (level_ff == '0) || (level_ff > LVL_W'(STACK_ENTRIES));
   assign stk_wr_en   = cmd.call && !stack_full;

   rcrt_ram #(
      .WIDTH (32),
      .DEPTH (STACK_ENTRIES)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (level_ff[STK_AW-1:0]),
      .wr_data (pc_ff + RET_STEP),
      .rd_addr (level_ff[STK_AW-1:0]),
      .rd_data (stk_rd_data)
   );

   assign active_n = (symbol_count_ff > 9'(SYMBOL_ENTRIES)) ? SCNT_W'(SYMBOL_ENTRIES)
                                                           : SCNT_W'(symbol_count_ff);
   assign tbl_base = tbl_rd_data[31:0];
   assign tbl_size = tbl_rd_data[63:32];
   assign key_off  = key_ff - tbl_base;

   assign inst_low    = inst_ff[11:0];
   assign jalr_imm    = {{20{inst_ff[31]}}, inst_ff[31:20]};
   assign jal_imm     = {{11{inst_ff[31]}}, inst_ff[31], inst_ff[19:12], inst_ff[20],
                         inst_ff[30:21], 1'b0};
   assign call_target = (inst_low == LOW_JALR) ? ((rs1_ff + jalr_imm) & ALIGN_MASK)
                                               : (pc_ff + jal_imm);

   always_comb begin
      status.scan_end    = (scan_idx_ff >= active_n);
      status.hit         = (key_ff >= tbl_base) && (key_off < tbl_size);
      status.is_call     = (inst_low == LOW_JAL) || (inst_low == LOW_JALR);
      status.is_ret      = (inst_ff == INST_RET);
      status.stack_empty = stack_empty;
      status.out_free    = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      level_in    = level_ff;
      scan_idx_in = scan_idx_ff;
      inst_in     = inst_ff;
      pc_in       = pc_ff;
      rs1_in      = rs1_ff;
      key_in      = key_ff;
      kind_in     = kind_ff;
      caller_in   = caller_ff;
      callee_in   = callee_ff;
      found_in    = found_ff;
      err_in      = err_ff;
      target_in   = target_ff;
      depth_in    = depth_ff;

      if (cmd.load || cmd.trace_start) begin
         kind_in   = EVT_NONE;
         caller_in = '0;
         callee_in = '0;
         found_in  = 1'b0;
         err_in    = 1'b0;
         target_in = '0;
         depth_in  = '0;
      end
      if (cmd.trace_start) begin
         inst_in     = req_instruction;
         pc_in       = req_program_counter;
         rs1_in      = req_rs1_value;
         key_in      = req_program_counter;
         scan_idx_in = '0;
      end
      if (cmd.scan_next) begin
         scan_idx_in = scan_idx_ff + SCNT_W'(1);
      end
      if (cmd.call) begin
         kind_in     = EVT_CALL;
         caller_in   = 8'(scan_idx_ff);
         target_in   = call_target;
         key_in      = call_target;
         depth_in    = 10'(level_ff);
         scan_idx_in = '0;
         if (stack_full) begin
            err_in = 1'b1;
         end else begin
            level_in = level_ff + LVL_W'(1);
         end
      end
      if (cmd.ret) begin
         kind_in   = EVT_RET;
         caller_in = 8'(scan_idx_ff);
         if (stack_empty) begin
            err_in = 1'b1;
         end else begin
            level_in = level_ff - LVL_W'(1);
         end
      end
      if (cmd.pop_take) begin
         target_in   = stk_rd_data;
         key_in      = stk_rd_data;
         depth_in    = 10'(level_ff);
         scan_idx_in = '0;
      end
      if (cmd.callee_hit) begin
         callee_in = 8'(scan_idx_ff);
         found_in  = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_idx_in;
      inst_ff     <= inst_in;
      pc_ff       <= pc_in;
      rs1_ff      <= rs1_in;
      key_ff      <= key_in;
      kind_ff     <= kind_in;
      caller_ff   <= caller_in;
      callee_ff   <= callee_in;
      found_ff    <= found_in;
      err_ff      <= err_in;
      target_ff   <= target_in;
      depth_ff    <= depth_in;
      if (cmd.emit) begin
         rsp_kind_ff   <= kind_ff;
         rsp_caller_ff <= caller_ff;
         rsp_callee_ff <= callee_ff;
         rsp_found_ff  <= found_ff;
         rsp_err_ff    <= err_ff;
         rsp_target_ff <= target_ff;
         rsp_depth_ff  <= depth_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_event_kind     = rsp_kind_ff;
   assign rsp_caller_index   = rsp_caller_ff;
   assign rsp_callee_index   = rsp_callee_ff;
   assign rsp_callee_found   = rsp_found_ff;
   assign rsp_target_address = rsp_target_ff;
   assign rsp_call_depth     = rsp_depth_ff;
   assign rsp_stack_error    = rsp_err_ff;

   `RCRT_ASSERT_NOW(a_level_bound, clock, reset, 1'b1,
      level_ff <= LVL_W'(STACK_ENTRIES), "return stack level out of range")
   `RCRT_ASSERT_NOW(a_found_needs_event, clock, reset, rsp_valid && rsp_callee_found,
      rsp_event_kind != EVT_NONE, "callee reported without an event")
   `RCRT_ASSERT_NOW(a_empty_pop_clean, clock, reset,
      rsp_valid && rsp_stack_error && (rsp_event_kind == EVT_RET),
      (rsp_target_address == '0) && (rsp_call_depth == '0), "empty-stack return carries data")

endmodule

`default_nettype wire

// ----- sv/riscv_call_return_tracer.sv -----
// Top level of the RV32 function call and return tracer.
//
//   Channel  Direction  Handshake               Content
//   req_     in         req_valid / req_ready   symbol load or one retired instruction
//   rsp_     out        rsp_valid / rsp_ready   one event item per request item
//   csr_     in         csr_valid / csr_ready   symbol_count register write
//
// A load item goes from idle straight to result hand-off. A traced instruction
// scans the symbol table for the pc (a miss scans all n active entries, n = active
// symbol count); on a hit with a call, or a return with a non-empty stack, the return
// stack is updated and a second scan looks up the callee. Each scan reads
// one entry at a time through the single read port of the symbol table RAM, in a
// read state and a compare state. Reset is synchronous; no clearing pass is needed.
// A new item is taken while the previous result still waits on rsp_ready.
`default_nettype none

module riscv_call_return_tracer
   import rcrt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [8:0]  csr_symbol_count,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [7:0]  req_entry_index,
   input  logic [31:0] req_entry_base,
   input  logic [31:0] req_entry_size,
   input  logic [31:0] req_instruction,
   input  logic [31:0] req_program_counter,
   input  logic [31:0] req_rs1_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_event_kind,
   output logic [7:0]  rsp_caller_index,
   output logic [7:0]  rsp_callee_index,
   output logic        rsp_callee_found,
   output logic [31:0] rsp_target_address,
   output logic [9:0]  rsp_call_depth,
   output logic        rsp_stack_error
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   rcrt_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .status      (status),
      .cmd         (cmd)
   );

   rcrt_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_symbol_count    (csr_symbol_count),
      .req_entry_index     (req_entry_index),
      .req_entry_base      (req_entry_base),
      .req_entry_size      (req_entry_size),
      .req_instruction     (req_instruction),
      .req_program_counter (req_program_counter),
      .req_rs1_value       (req_rs1_value),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_event_kind      (rsp_event_kind),
      .rsp_caller_index    (rsp_caller_index),
      .rsp_callee_index    (rsp_callee_index),
      .rsp_callee_found    (rsp_callee_found),
      .rsp_target_address  (rsp_target_address),
      .rsp_call_depth      (rsp_call_depth),
      .rsp_stack_error     (rsp_stack_error)
   );

endmodule

`default_nettype wire

// ----- sim/riscv_call_return_tracer_tb.sv -----
// Self-checking testbench for the RV32 call and return tracer.
`timescale 1ns / 1ps

import rcrt_pkg::*;

typedef struct {
   bit        cmd;
   bit [7:0]  slot;
   bit [31:0] base;
   bit [31:0] size;
   bit [31:0] inst;
   bit [31:0] pc;
   bit [31:0] rs1;
} tracer_req_type;

typedef struct packed {
   logic [1:0]  kind;
   logic [7:0]  caller;
   logic [7:0]  callee;
   logic        found;
   logic [31:0] target;
   logic [9:0]  depth;
   logic        err;
} tracer_evt_type;

class call_event_board;
   bit [31:0]      fn_base [SYMBOL_ENTRIES];
   bit [31:0]      fn_size [SYMBOL_ENTRIES];
   bit [31:0]      ret_addr [STACK_ENTRIES];
   int unsigned    ret_level;
   int unsigned    sym_count;
   int unsigned    result_count;
   int unsigned    mismatches;
   tracer_evt_type pending_events [$];

   function int unsigned active_count();
      return (sym_count > SYMBOL_ENTRIES) ? SYMBOL_ENTRIES : sym_count;
   endfunction

   function bit find_function(input bit [31:0] addr, output bit [7:0] idx);
      idx = '0;
      for (int i = 0; i < active_count(); i++) begin
         if (addr >= fn_base[i] && addr - fn_base[i] < fn_size[i]) begin
            idx = 8'(i);
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function void note_item(tracer_req_type it);
      tracer_evt_type ev;
      bit [7:0]       ci;
      bit [7:0]       cj;
      bit [31:0]      tgt;
      ev = '0;
      if (it.cmd == CMD_LOAD) begin
         fn_base[it.slot] = it.base;
         fn_size[it.slot] = it.size;
      end else if (find_function(it.pc, ci)) begin
         if (it.inst[11:0] == LOW_JALR || it.inst[11:0] == LOW_JAL) begin
            if (it.inst[11:0] == LOW_JALR) begin
               tgt = (it.rs1 + {{20{it.inst[31]}}, it.inst[31:20]}) & ALIGN_MASK;
            end else begin
               tgt = it.pc + {{11{it.inst[31]}}, it.inst[31], it.inst[19:12],
                              it.inst[20], it.inst[30:21], 1'b0};
            end
            ev.kind   = EVT_CALL;
            ev.caller = ci;
            ev.found  = find_function(tgt, cj);
            ev.callee = cj;
            ev.target = tgt;
            ev.depth  = 10'(ret_level);
            if (ret_level < STACK_ENTRIES) begin
               ret_addr[ret_level] = it.pc + RET_STEP;
               ret_level++;
            end else begin
               ev.err = 1'b1;
            end
         end else if (it.inst == INST_RET) begin
            ev.kind   = EVT_RET;
            ev.caller = ci;
            if (ret_level == 0) begin
               ev.err = 1'b1;
            end else begin
               ret_level--;
               tgt       = ret_addr[ret_level];
               ev.found  = find_function(tgt, cj);
               ev.callee = cj;
               ev.target = tgt;
               ev.depth  = 10'(ret_level);
            end
         end
      end
      pending_events.push_back(ev);
   endfunction

   task report(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("result %0d: %s is 0x%0h, expected 0x%0h", result_count, what, got, want);
   endtask

   task check_event(tracer_evt_type got);
      tracer_evt_type want;
      result_count++;
      if (pending_events.size() == 0) begin
         report("result with no item outstanding, event_kind", 32'(got.kind), 32'd0);
         return;
      end
      want = pending_events.pop_front();
      if (got.kind !== want.kind)
         report("event_kind", 32'(got.kind), 32'(want.kind));
      if (got.caller !== want.caller)
         report("caller_index", 32'(got.caller), 32'(want.caller));
      if (got.callee !== want.callee)
         report("callee_index", 32'(got.callee), 32'(want.callee));
      if (got.found !== want.found)
         report("callee_found", 32'(got.found), 32'(want.found));
      if (got.target !== want.target)
         report("target_address", got.target, want.target);
      if (got.depth !== want.depth)
         report("call_depth", 32'(got.depth), 32'(want.depth));
      if (got.err !== want.err)
         report("stack_error", 32'(got.err), 32'(want.err));
   endtask
endclass

module riscv_call_return_tracer_tb;

   localparam int       ITEM_GOAL    = 1170;
   localparam int       STORM_ITEMS  = 530;
   localparam int       CYCLE_LIMIT  = 6_000_000;
   localparam int       DRAIN_CYCLES = 1100;
   localparam int       MAX_IDLE     = 8;
   localparam bit [4:0] REG_RA       = 5'd1;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [8:0]  csr_symbol_count = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_command = 1'b0;
   logic [7:0]  req_entry_index = '0;
   logic [31:0] req_entry_base = '0;
   logic [31:0] req_entry_size = '0;
   logic [31:0] req_instruction = '0;
   logic [31:0] req_program_counter = '0;
   logic [31:0] req_rs1_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_event_kind;
   logic [7:0]  rsp_caller_index;
   logic [7:0]  rsp_callee_index;
   logic        rsp_callee_found;
   logic [31:0] rsp_target_address;
   logic [9:0]  rsp_call_depth;
   logic        rsp_stack_error;

   call_event_board board = new();
   int unsigned     item_total = 0;
   int unsigned     result_total = 0;
   int unsigned     ready_hold = 0;
   int unsigned     stall;
   int unsigned     cycle_count = 0;

   riscv_call_return_tracer u_top (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_symbol_count    (csr_symbol_count),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_command         (req_command),
      .req_entry_index     (req_entry_index),
      .req_entry_base      (req_entry_base),
      .req_entry_size      (req_entry_size),
      .req_instruction     (req_instruction),
      .req_program_counter (req_program_counter),
      .req_rs1_value       (req_rs1_value),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_event_kind      (rsp_event_kind),
      .rsp_caller_index    (rsp_caller_index),
      .rsp_callee_index    (rsp_callee_index),
      .rsp_callee_found    (rsp_callee_found),
      .rsp_target_address  (rsp_target_address),
      .rsp_call_depth      (rsp_call_depth),
      .rsp_stack_error     (rsp_stack_error)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         board.check_event({rsp_event_kind, rsp_caller_index, rsp_callee_index,
                            rsp_callee_found, rsp_target_address, rsp_call_depth,
                            rsp_stack_error});
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         ready_hold <= 0;
      end else if (rsp_valid && rsp_ready) begin
         result_total <= result_total + 1;
         stall = (result_total % 89 < 20) ? 0 : $urandom_range(0, MAX_IDLE);
         rsp_ready  <= (stall == 0);
         ready_hold <= stall;
      end else if (ready_hold > 1) begin
         ready_hold <= ready_hold - 1;
      end else begin
         ready_hold <= 0;
         rsp_ready  <= 1'b1;
      end
   end

   task automatic send_item(input tracer_req_type it);
      int unsigned gap;
      gap = (item_total % 97 < 20) ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_command         <= it.cmd;
      req_entry_index     <= it.slot;
      req_entry_base      <= it.base;
      req_entry_size      <= it.size;
      req_instruction     <= it.inst;
      req_program_counter <= it.pc;
      req_rs1_value       <= it.rs1;
      do @(posedge clock); while (!req_ready);
      board.note_item(it);
      item_total++;
   endtask

   task automatic load_entry(bit [7:0] slot, bit [31:0] base, bit [31:0] size);
      tracer_req_type it;
      it = '{cmd: CMD_LOAD, slot: slot, base: base, size: size,
             inst: $urandom, pc: $urandom, rs1: $urandom};
      send_item(it);
   endtask

   task automatic trace_instr(bit [31:0] inst, bit [31:0] pc, bit [31:0] rs1);
      tracer_req_type it;
      it = '{cmd: CMD_TRACE, slot: 8'($urandom), base: $urandom, size: $urandom,
             inst: inst, pc: pc, rs1: rs1};
      send_item(it);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (board.pending_events.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_symbol_count(bit [8:0] value);
      csr_valid        <= 1'b1;
      csr_symbol_count <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid       <= 1'b0;
      board.sym_count = 32'(value);
   endtask

   function automatic bit [31:0] jal_word(bit [20:0] imm, bit [4:0] rd);
      return {imm[20], imm[10:1], imm[11], imm[19:12], rd, LOW_JAL[6:0]};
   endfunction

   function automatic bit [31:0] jalr_word(bit [11:0] imm, bit [4:0] rd);
      return {imm, 5'($urandom), 3'($urandom), rd, LOW_JALR[6:0]};
   endfunction

   function automatic bit [31:0] addr_in_entry(int unsigned j);
      bit [31:0] span;
      span = board.fn_size[j];
      if (span == 0) return board.fn_base[j];
      return board.fn_base[j] + $urandom_range(0, (span > 32'h1_0000) ? 32'hFFFF : span - 1);
   endfunction

   function automatic bit [31:0] live_addr();
      if (board.active_count() == 0) return $urandom;
      return addr_in_entry($urandom_range(0, board.active_count() - 1));
   endfunction

   function automatic void random_entry(output bit [31:0] base, output bit [31:0] size);
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: begin
            base = ($urandom_range(0, 15) << 16) | ($urandom & 32'h0000_FFFC);
            size = $urandom_range(1, 32'h3000);
         end
         6, 7: begin
            base = $urandom;
            size = $urandom_range(0, 32'hFFFF);
         end
         8: begin
            base = $urandom;
            size = $urandom;
         end
         default: begin
            base = $urandom;
            size = '0;
         end
      endcase
   endfunction

   task automatic trace_call(bit [31:0] pc);
      bit [31:0] dest;
      bit [31:0] diff;
      bit [11:0] imm12;
      dest = ($urandom_range(0, 9) < 7) ? live_addr() : $urandom;
      if ($urandom_range(0, 1) == 1) begin
         diff = dest - pc;
         if (!(diff < 32'h0010_0000 || diff >= 32'hFFF0_0000)) diff = $urandom;
         trace_instr(jal_word(diff[20:0], REG_RA), pc, $urandom);
      end else begin
         imm12 = 12'($urandom);
         trace_instr(jalr_word(imm12, REG_RA), pc, dest - {{20{imm12[11]}}, imm12});
      end
   endtask

   task automatic random_item();
      int unsigned pick;
      bit [4:0]    rd;
      bit [31:0]   base;
      bit [31:0]   size;
      pick = $urandom_range(0, 99);
      rd   = 5'($urandom);
      if (rd == REG_RA) rd = '0;
      if (pick < 35) begin
         trace_call(live_addr());
      end else if (pick < 65) begin
         trace_instr(INST_RET, live_addr(), $urandom);
      end else if (pick < 69) begin
         trace_call($urandom);
      end else if (pick < 72) begin
         trace_instr(INST_RET, $urandom, $urandom);
      end else if (pick < 80) begin
         case ($urandom_range(0, 2))
            0: trace_instr(jal_word(21'($urandom), rd), live_addr(), $urandom);
            1: trace_instr(jalr_word(12'($urandom), rd), live_addr(), $urandom);
            default: trace_instr(INST_RET ^ (32'h1 << $urandom_range(0, 31)), live_addr(),
                                 $urandom);
         endcase
      end else if (pick < 93) begin
         trace_instr($urandom, live_addr(), $urandom);
      end else begin
         random_entry(base, size);
         load_entry(8'($urandom_range(4, 255)), base, size);
      end
   endtask

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("simulation failed");
      $finish;
   end

   initial begin
      bit [31:0]   base;
      bit [31:0]   size;
      int unsigned cnt;
      int unsigned n;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      write_symbol_count(9'd0);

      // With no symbols loaded every trace misses.
      trace_instr(INST_RET, 32'h0000_1000, $urandom);
      trace_instr(jal_word(21'h100, REG_RA), 32'h0000_1000, $urandom);

      load_entry(8'd0, 32'h0000_1000, 32'h0000_0100);
      load_entry(8'd1, 32'h0000_1080, 32'h0000_0200);
      load_entry(8'd2, 32'h0000_0000, 32'h0000_0000);
      load_entry(8'd3, 32'hFFFF_FF00, 32'h0000_00F0);
      for (int s = 4; s < 255; s++) begin
         random_entry(base, size);
         load_entry(8'(s), base, size);
      end
      load_entry(8'd255, 32'hFFFF_FFF0, 32'hFFFF_FFFF);

      settle();
      write_symbol_count(9'd4);
      trace_instr(INST_RET, 32'h0000_1010, $urandom);
      trace_instr(jal_word(21'h000100, REG_RA), 32'h0000_1000, $urandom);
      trace_instr(jalr_word(12'hFFF, REG_RA), 32'h0000_1100, 32'hFFFF_FF11);
      trace_instr(jal_word(21'h100000, REG_RA), 32'hFFFF_FF40, $urandom);
      trace_instr(jal_word(21'h000040, 5'd0), 32'h0000_1000, $urandom);
      trace_instr(jalr_word(12'h000, 5'd5), 32'h0000_1000, $urandom);
      trace_instr(INST_RET | 32'h0010_0000, 32'h0000_1000, $urandom);
      trace_instr(INST_RET, 32'h0000_10FF, $urandom);
      trace_instr(INST_RET, 32'h0000_1100, $urandom);
      trace_instr(INST_RET, 32'h0000_0FFF, $urandom);
      trace_instr(INST_RET, 32'h0000_1280, $urandom);
      trace_instr(INST_RET, 32'h0000_127F, $urandom);
      trace_instr(INST_RET, 32'h0000_1000, $urandom);
      trace_instr(jal_word(21'h000018, REG_RA), 32'hFFFF_FFEC, $urandom);
      trace_instr(jal_word(21'h000008, REG_RA), 32'h0000_2000, $urandom);
      trace_instr(INST_RET, 32'hFFFF_FF00, $urandom);

      settle();
      write_symbol_count(9'd256);
      trace_instr(INST_RET, 32'hFFFF_FFF8, $urandom);
      trace_call(32'hFFFF_FFF4);
      trace_instr(INST_RET, live_addr(), $urandom);

      settle();
      write_symbol_count(9'd511);
      trace_call(live_addr());
      trace_instr(INST_RET, 32'h0000_0008, $urandom);

      while (item_total < ITEM_GOAL - STORM_ITEMS) begin
         case ($urandom_range(0, 9))
            0: begin
               cnt = ($urandom_range(0, 1) == 1) ? 256 : $urandom_range(257, 511);
               n   = 5;
            end
            1: begin
               cnt = 0;
               n   = 12;
            end
            default: begin
               cnt = $urandom_range(1, 32);
               n   = 40;
            end
         endcase
         settle();
         write_symbol_count(9'(cnt));
         repeat (n) random_item();
      end

      // Fill the return stack, push past the top, then unwind a little.
      settle();
      write_symbol_count(9'd4);
      while (board.ret_level < STACK_ENTRIES) begin
         trace_call(32'h0000_1000 + $urandom_range(0, 32'hFF));
      end
      repeat (8) trace_call(32'h0000_1000 + $urandom_range(0, 32'hFF));
      repeat (10) trace_instr(INST_RET, 32'h0000_1000 + $urandom_range(0, 32'hFF), $urandom);
      repeat (6) trace_call(32'h0000_1000 + $urandom_range(0, 32'hFF));

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
